// ===== rtl/core/rbm_pkg.sv =====
package rbm_pkg;

	// Configuration port geometry
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int ROW_W        = 12;

	// Frame height is clamped to this many rows
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = 13'd3;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = 11'd3;

	// Reset values of the size registers
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

	// Register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

// ===== rtl/core/rbm_ram.sv =====
// Single-port-write, single-port-read RAM with registered read (old data on collision)
module rbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/raster_3x3_region_boundary_marker_top.sv =====
// 3x3 region boundary marker. Accepts one raster-order sample per clock unless
// stalled and produces, for every interior pixel, a flag that is set when the
// center is the maximum of its 3x3 neighborhood and the neighborhood is not
// uniform. Border pixels give no result. The pixel at row r, column c (r >= 2,
// c >= 2) completes the window of center (r-1, c-1); that result passes from the
// stage-1 registers into the output register. Throughput is one pixel per clock
// while the output is not stalled, set by the single read-modify-write of the two
// line-buffer RAMs per pixel; a pixel that immediately revisits the same column
// (back-to-back frame_start) is served by forwarding. The line buffers need no
// clearing pass. image_width and image_height are clamped to 3..MAX_WIDTH and
// 3..4096; the user must write them only while the block is idle, which the block itself does not enforce.
module raster_3x3_region_boundary_marker_top
	import rbm_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          frame_start,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_boundary,
	output logic [ROW_W-1:0]              center_row,
	output logic [$clog2(MAX_WIDTH)-1:0]  center_col,
	output logic                          last_of_frame
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int MWB = $clog2(MAX_WIDTH + 1);
	localparam int XW  = (MWB > WIDTH_REG_W) ? MWB : WIDTH_REG_W;
	localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);

	// configuration registers
	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size
	logic [XW-1:0]           w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;

	always_comb begin
		w_eff = XW'(image_width_q);
		if (image_width_q < WIDTH_MIN) begin
			w_eff = XW'(WIDTH_MIN);
		end else if (XW'(image_width_q) > MAXW_X) begin
			w_eff = MAXW_X;
		end
		h_eff = image_height_q;
		if (image_height_q < HEIGHT_MIN) begin
			h_eff = HEIGHT_MIN;
		end else if (image_height_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end
	end

	// handshake and stage control
	logic in_xfer;
	logic s1_valid;
	logic s1_adv;
	logic s1_has_res;
	logic out_valid_q;

	assign s1_adv   = !s1_has_res || !out_valid_q || out_ready;
	assign in_ready = !s1_valid || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	// position of the incoming pixel
	logic [CW-1:0]    col_cnt_q;
	logic [ROW_W-1:0] row_cnt_q;
	logic [XW-1:0]    c_x;
	logic [HEIGHT_REG_W-1:0] r_x;
	logic [CW-1:0]    c_new;
	logic [ROW_W-1:0] r_new;
	logic             col_wrap;
	logic             row_wrap;

	always_comb begin
		c_x = frame_start ? '0 : XW'(col_cnt_q);
		r_x = frame_start ? '0 : HEIGHT_REG_W'(row_cnt_q);
		if (c_x >= w_eff) begin
			c_x = w_eff - XW'(1);
		end
		if (r_x >= h_eff) begin
			r_x = h_eff - HEIGHT_REG_W'(1);
		end
		c_new    = c_x[CW-1:0];
		r_new    = r_x[ROW_W-1:0];
		col_wrap = (c_x + XW'(1)) >= w_eff;
		row_wrap = (r_x + HEIGHT_REG_W'(1)) >= h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (in_xfer) begin
			if (col_wrap) begin
				col_cnt_q <= '0;
				row_cnt_q <= row_wrap ? '0 : r_new + ROW_W'(1);
			end else begin
				col_cnt_q <= c_new + CW'(1);
				row_cnt_q <= r_new;
			end
		end
	end

	// stage 1 registers: pixel info while the line buffers are read
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [CW-1:0]          col_s1;
	logic [ROW_W-1:0]       crow_s1;
	logic [CW-1:0]          ccol_s1;
	logic                   last_s1;
	logic                   fwd_s1;
	logic [SAMPLE_BITS-1:0] fwd_top_s1;
	logic [SAMPLE_BITS-1:0] fwd_mid_s1;
	logic [SAMPLE_BITS-1:0] up_rd;
	logic [SAMPLE_BITS-1:0] mid_rd;
	logic [SAMPLE_BITS-1:0] top_s1;
	logic [SAMPLE_BITS-1:0] mid_s1;

	// forwarding covers a read of the column that stage 1 writes this cycle
	assign top_s1 = fwd_s1 ? fwd_top_s1 : up_rd;
	assign mid_s1 = fwd_s1 ? fwd_mid_s1 : mid_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			s1_has_res <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (in_xfer) begin
			s1_valid   <= 1'b1;
			s1_has_res <= (r_new >= ROW_W'(2)) && (c_new >= CW'(2));
			fwd_s1     <= s1_valid && (col_s1 == c_new);
		end else if (s1_adv) begin
			s1_valid   <= 1'b0;
			s1_has_res <= 1'b0;
			fwd_s1     <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1  <= sample;
			col_s1     <= c_new;
			crow_s1    <= r_new - ROW_W'(1);
			ccol_s1    <= c_new - CW'(1);
			last_s1    <= (HEIGHT_REG_W'(r_new) == h_eff - HEIGHT_REG_W'(1)) &&
				(XW'(c_new) == w_eff - XW'(1));
			fwd_top_s1 <= mid_s1;
			fwd_mid_s1 <= sample_s1;
		end
	end

	// line buffers: upper row two back, middle row one back
	logic wb;
	assign wb = s1_valid && s1_adv;

	rbm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (wb),
		.waddr (col_s1),
		.wdata (mid_s1),
		.re    (in_xfer),
		.raddr (c_new),
		.rdata (up_rd)
	);

	rbm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (wb),
		.waddr (col_s1),
		.wdata (sample_s1),
		.re    (in_xfer),
		.raddr (c_new),
		.rdata (mid_rd)
	);

	// window columns c-2 and c-1 (top, middle, bottom)
	logic [SAMPLE_BITS-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (wb) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= sample_s1;
		end
	end

	// center is maximum iff no neighbor exceeds it
	logic [SAMPLE_BITS-1:0] win [9];
	logic                   uniform;
	logic                   ctr_max;
	logic                   flag;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			win[i] = win_q[i];
		end
		win[6]  = top_s1;
		win[7]  = mid_s1;
		win[8]  = sample_s1;
		uniform = 1'b1;
		ctr_max = 1'b1;
		for (int k = 0; k < 9; k++) begin
			if (win[k] != win[0]) begin
				uniform = 1'b0;
			end
			if (win[k] > win[4]) begin
				ctr_max = 1'b0;
			end
		end
		flag = !uniform && ctr_max;
	end

	// output register
	logic             is_boundary_q;
	logic [ROW_W-1:0] center_row_q;
	logic [CW-1:0]    center_col_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb && s1_has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb && s1_has_res) begin
			is_boundary_q <= flag;
			center_row_q  <= crow_s1;
			center_col_q  <= ccol_s1;
			last_q        <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_boundary   = is_boundary_q;
	assign center_row    = center_row_q;
	assign center_col    = center_col_q;
	assign last_of_frame = last_q;

	// forwarding only ever applies to a live stage-1 pixel
	assert property (@(posedge clk) disable iff (!arst_n) fwd_s1 |-> s1_valid)
		else $error("forward flag without stage-1 pixel");

	// a stalled stage 1 must keep its line-buffer read data
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_adv) |=> ($stable(up_rd) && $stable(mid_rd)))
		else $error("line buffer read data lost during stall");

	// the last result of a frame sits one in from the bottom-right corner
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |->
		((HEIGHT_REG_W'(center_row_q) == h_eff - HEIGHT_REG_W'(2)) &&
		(XW'(center_col_q) == w_eff - XW'(2))))
		else $error("last_of_frame on wrong position");

	// results are never for pixels of the top row or the left column
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((center_row_q != '0) && (center_col_q != '0)))
		else $error("result for border pixel");

endmodule

// ===== dv/tb_raster_3x3_region_boundary_marker_top.sv =====
`timescale 1ns / 1ps

module tb_raster_3x3_region_boundary_marker_top;
	import rbm_pkg::*;

	localparam int LINE_PIXELS  = 1024;
	localparam int PIX_BITS     = 16;
	localparam int COL_W        = $clog2(LINE_PIXELS);
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	// One judged center pixel
	typedef struct packed {
		logic             boundary;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             frame_end;
	} mark_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    cfg_we      = 1'b0;
	logic                    cfg_index   = 1'b0;
	logic [CFG_DATA_W-1:0]   cfg_data    = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic [PIX_BITS-1:0]     sample      = '0;
	logic                    frame_start = 1'b0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic                    is_boundary;
	logic [ROW_W-1:0]        center_row;
	logic [COL_W-1:0]        center_col;
	logic                    last_of_frame;

	// Shadow copy of the block state
	logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
	logic [PIX_BITS-1:0]     shadow_upper  [LINE_PIXELS];
	logic [PIX_BITS-1:0]     shadow_middle [LINE_PIXELS];
	logic [PIX_BITS-1:0]     shadow_win    [6];
	int unsigned             col_pos = 0;
	int unsigned             row_pos = 0;

	mark_t       pending_marks[$];
	int unsigned fail_count     = 0;
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned quiet_cycles   = 0;

	raster_3x3_region_boundary_marker_top #(
		.MAX_WIDTH   (LINE_PIXELS),
		.SAMPLE_BITS (PIX_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.is_boundary   (is_boundary),
		.center_row    (center_row),
		.center_col    (center_col),
		.last_of_frame (last_of_frame)
	);

	always #1 clk = ~clk;

	// Advance the shadow state by one pixel and queue the mark it completes
	function automatic void judge_pixel(input logic [PIX_BITS-1:0] s, input logic fs);
		int unsigned        w, h, r, c, k;
		logic [PIX_BITS-1:0] top, mid, peak;
		logic [PIX_BITS-1:0] hood [9];
		logic               flat;
		mark_t              m;
		w = width_reg;
		if (w < WIDTH_MIN) w = WIDTH_MIN;
		if (w > LINE_PIXELS) w = LINE_PIXELS;
		h = height_reg;
		if (h < HEIGHT_MIN) h = HEIGHT_MIN;
		if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		// counters left past the frame by a size change are pinned to the edge
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;
		top = shadow_upper[c];
		mid = shadow_middle[c];
		if (r >= 2 && c >= 2) begin
			for (k = 0; k < 6; k++) hood[k] = shadow_win[k];
			hood[6] = top;
			hood[7] = mid;
			hood[8] = s;
			peak = hood[0];
			flat = 1'b1;
			for (k = 1; k < 9; k++) begin
				if (hood[k] != hood[0]) flat = 1'b0;
				if (hood[k] > peak) peak = hood[k];
			end
			m.boundary  = !flat && (hood[4] == peak);
			m.row       = ROW_W'(r - 1);
			m.col       = COL_W'(c - 1);
			m.frame_end = (r == h - 1) && (c == w - 1);
			pending_marks.push_back(m);
		end
		// line buffers and window shift
		shadow_upper[c]  = mid;
		shadow_middle[c] = s;
		for (k = 0; k < 3; k++) shadow_win[k] = shadow_win[k + 3];
		shadow_win[3] = top;
		shadow_win[4] = mid;
		shadow_win[5] = s;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	// Material value drawn per frame style: small spread, near-flat, or full range
	function automatic logic [PIX_BITS-1:0] draw_material(input int unsigned style,
			input logic [PIX_BITS-1:0] base);
		case (style)
			0: begin
				return base + PIX_BITS'($urandom_range(3, 0));
			end
			1: begin
				return ($urandom_range(11, 0) == 0) ? PIX_BITS'($urandom) : base;
			end
			default: begin
				return PIX_BITS'($urandom);
			end
		endcase
	endfunction

	// Send one pixel; returns on the falling edge after its transfer with valid
	// still high, so a following call that draws no idle keeps the channel busy without a bubble
	task automatic push_pixel(input logic [PIX_BITS-1:0] s, input logic fs);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= s;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		judge_pixel(s, fs);
	endtask

	// One register write; the enable drops again after the edge that takes it, so back-to-back
	// writes never drive it twice on the same edge
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
		else height_reg = val[HEIGHT_REG_W-1:0];
	endtask

	// Stop sending, wait for every pending mark, then let the pipeline empty
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_marks.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Hand-built 3x3 frames: flat neighborhood, tied maximum, center below max
	task automatic test_window_cases();
		logic [PIX_BITS-1:0] tie_frame [9];
		logic [PIX_BITS-1:0] low_frame [9];
		int unsigned         k;
		tie_frame = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
			16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
		low_frame = '{16'h8000, 16'h00FF, 16'hFFFF, 16'h7FFF, 16'h0000,
			16'h0001, 16'h1234, 16'hFF00, 16'h5555};
		settle_block();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
		// flat neighborhood never marks, even though the center is the max
		for (k = 0; k < 9; k++) push_pixel(16'h5A5A, k == 0);
		// stream wraps into the next frame without frame_start
		for (k = 0; k < 9; k++) push_pixel(tie_frame[k], 1'b0);
		// redundant frame_start right at a frame boundary
		for (k = 0; k < 9; k++) push_pixel(low_frame[k], k == 0);
	endtask

	// Small random frames, some cut short by frame_start, some wrapping into the next without frame_start
	task automatic test_random_frames(input int unsigned item_goal);
		int unsigned         sent, w, h, w_val, h_val, frame_len, style, k;
		logic [PIX_BITS-1:0] base;
		logic                fs_next, broken;
		sent = 0;
		while (sent < item_goal) begin
			w = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 3);
			h = $urandom_range(7, 3);
			// below-range sizes clamp to three
			w_val = (w == 3 && $urandom_range(1, 0)) ? $urandom_range(2, 0) : w;
			h_val = (h == 3 && $urandom_range(1, 0)) ? $urandom_range(2, 0) : h;
			settle_block();
			write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
			fs_next = 1'b1;
			repeat ($urandom_range(3, 1)) begin
				frame_len = w * h;
				broken    = ($urandom_range(99, 0) < 15);
				if (broken) frame_len = $urandom_range(frame_len - 1, 1);
				style = $urandom_range(2, 0);
				base  = PIX_BITS'($urandom);
				for (k = 0; k < frame_len; k++) begin
					push_pixel(draw_material(style, base), (k == 0) && fs_next);
					sent++;
				end
				fs_next = broken ? 1'b1 : logic'($urandom_range(1, 0));
			end
		end
	endtask

	// Size clamping and counters left past a shrunken frame
	task automatic test_size_extremes();
		int unsigned         k;
		logic [PIX_BITS-1:0] base;
		settle_block();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		for (k = 0; k < 9; k++) push_pixel(PIX_BITS'($urandom), k == 0);
		settle_block();
		// all-ones data: width clamps to the line length, height to the row limit
		write_reg(REG_IMAGE_WIDTH, '1);
		write_reg(REG_IMAGE_HEIGHT, '1);
		base = PIX_BITS'($urandom);
		for (k = 0; k < 40; k++)
			push_pixel(draw_material(0, base), k == 0);
		settle_block();
		// column counter now sits beyond the new last column
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(7));
		repeat (30) push_pixel(draw_material(0, base), 1'b0);
		settle_block();
		// row counter now sits beyond the new last row
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(5));
		repeat (40) push_pixel(draw_material(0, base), 1'b0);
	endtask

	// Receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	// Compare each output transfer with the oldest pending mark
	always @(posedge clk) begin : mark_check
		mark_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_marks.size() == 0) begin
				$error("unexpected result: row %0d col %0d", center_row, center_col);
				fail_count++;
			end else begin
				want = pending_marks.pop_front();
				if (is_boundary !== want.boundary) begin
					$error("is_boundary: expected %0d, got %0d", want.boundary, is_boundary);
					fail_count++;
				end
				if (center_row !== want.row) begin
					$error("center_row: expected %0d, got %0d", want.row, center_row);
					fail_count++;
				end
				if (center_col !== want.col) begin
					$error("center_col: expected %0d, got %0d", want.col, center_col);
					fail_count++;
				end
				if (last_of_frame !== want.frame_end) begin
					$error("last_of_frame: expected %0d, got %0d", want.frame_end,
						last_of_frame);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < LINE_PIXELS; i++) begin
			shadow_upper[i]  = '0;
			shadow_middle[i] = '0;
		end
		for (int i = 0; i < 6; i++) shadow_win[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct   = 17;
		sink_stall_pct = 55;
		test_window_cases();
		test_random_frames(170);

		src_idle_pct   = 55;
		sink_stall_pct = 17;
		test_random_frames(170);

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random_frames(150);
		test_size_extremes();

		settle_block();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rbm_pkg.sv
rtl/core/rbm_ram.sv
rtl/core/raster_3x3_region_boundary_marker_top.sv
dv/tb_raster_3x3_region_boundary_marker_top.sv
